### hw/rtl/gf2pa_pkg.sv
// ----------------------------------------------------------------------------
// gf2pa_pkg
// Shared types and constants of the GF(2) polynomial arithmetic unit:
// opcodes, controller and divider states, field widths.
// ----------------------------------------------------------------------------
package gf2pa_pkg;

    localparam int WIDTH_DEF = 32;
    localparam int FIELD_W   = 32;
    localparam int OP_W      = 3;
    localparam int EXT_W     = 64;

    localparam logic [EXT_W-1:0] ODD_PATTERN = 64'hAAAA_AAAA_AAAA_AAAA;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_MUL   = 3'd1,
        OP_DIV   = 3'd2,
        OP_GCD   = 3'd3,
        OP_DERIV = 3'd4,
        OP_SQRT  = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_GCD_CHK,
        ST_GCD_RUN
    } t_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_NORM,
        DV_STEP
    } t_div_state;

endpackage

### hw/rtl/gf2_polynomial_alu.sv
// ----------------------------------------------------------------------------
// gf2_polynomial_alu
// Arithmetic on polynomials over GF(2): add, truncated multiply, divide,
// gcd, derivative and square root, on WIDTH-bit coefficient vectors.
//
// A request is taken at a rising edge with start high and busy low; it
// carries i_opcode, i_operand_a and i_operand_b. Exactly one result comes
// back per request: o_result, o_remainder and o_div_by_zero are valid for
// the single cycle in which o_valid is high, and the receiver must take it
// then, as it cannot stall the block.
// Add, derivative, square root and unused opcodes answer in the next cycle
// and never raise busy, so they may be issued every cycle.
// Multiply runs one multiplier bit per cycle.
// Divide shifts the divisor up and then forms one quotient bit per cycle
// in the bit-serial divider. Gcd runs the same divider once per Euclid
// step: at most WIDTH + 1 divisions.
// Division by zero answers in the next cycle with the flag set.
// Reset clears the controller and the units; no request is pending after it.
// ----------------------------------------------------------------------------
module gf2_polynomial_alu #(
    parameter int WIDTH = gf2pa_pkg::WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [gf2pa_pkg::OP_W-1:0]     i_opcode,
    input  logic [gf2pa_pkg::FIELD_W-1:0]  i_operand_a,
    input  logic [gf2pa_pkg::FIELD_W-1:0]  i_operand_b,
    output logic                           o_valid,
    output logic [gf2pa_pkg::FIELD_W-1:0]  o_result,
    output logic [gf2pa_pkg::FIELD_W-1:0]  o_remainder,
    output logic                           o_div_by_zero
);
    import gf2pa_pkg::*;

    localparam int HALF_W = (WIDTH + 1) / 2;

    t_state           r_state, n_state;
    logic             r_valid, n_valid;
    logic [WIDTH-1:0] r_result, n_result;
    logic [WIDTH-1:0] r_remainder, n_remainder;
    logic             r_dbz, n_dbz;
    logic [WIDTH-1:0] r_ga, n_ga;
    logic [WIDTH-1:0] r_gb, n_gb;

    logic [EXT_W-1:0] a_ext, b_ext, res_ext, rem_ext;
    logic [WIDTH-1:0] a_w, b_w, sqrt_w, deriv_w;

    logic             mul_start, mul_done;
    logic [WIDTH-1:0] mul_product;
    logic             div_start, div_done;
    logic [WIDTH-1:0] div_dividend, div_divisor, div_quotient, div_remainder;

    assign a_ext = EXT_W'(i_operand_a);
    assign b_ext = EXT_W'(i_operand_b);
    assign a_w   = a_ext[WIDTH-1:0];
    assign b_w   = b_ext[WIDTH-1:0];

    assign deriv_w = (a_w & ODD_PATTERN[WIDTH-1:0]) >> 1;

    always_comb begin
        sqrt_w = '0;
        for (int k = 0; k < HALF_W; k++) begin
            sqrt_w[k] = a_w[2*k];
        end
    end

    gf2pa_mul #(.WIDTH(WIDTH)) u_mul (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (mul_start),
        .i_multiplicand (a_w),
        .i_multiplier   (b_w),
        .o_done         (mul_done),
        .o_product      (mul_product)
    );

    gf2pa_div #(.WIDTH(WIDTH)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result    <= n_result;
        r_remainder <= n_remainder;
        r_dbz       <= n_dbz;
        r_ga        <= n_ga;
        r_gb        <= n_gb;
    end

    always_comb begin
        n_state      = r_state;
        n_valid      = 1'b0;
        n_result     = r_result;
        n_remainder  = r_remainder;
        n_dbz        = r_dbz;
        n_ga         = r_ga;
        n_gb         = r_gb;
        mul_start    = 1'b0;
        div_start    = 1'b0;
        div_dividend = r_ga;
        div_divisor  = r_gb;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_result    = '0;
                    n_remainder = '0;
                    n_dbz       = 1'b0;
                    unique case (t_opcode'(i_opcode))
                        OP_ADD: begin
                            n_result = a_w ^ b_w;
                            n_valid  = 1'b1;
                        end
                        OP_MUL: begin
                            mul_start = 1'b1;
                            n_state   = ST_MUL;
                        end
                        OP_DIV: begin
                            if (b_w == '0) begin
                                n_remainder = a_w;
                                n_dbz       = 1'b1;
                                n_valid     = 1'b1;
                            end else begin
                                div_start    = 1'b1;
                                div_dividend = a_w;
                                div_divisor  = b_w;
                                n_state      = ST_DIV;
                            end
                        end
                        OP_GCD: begin
                            n_ga    = a_w;
                            n_gb    = b_w;
                            n_state = ST_GCD_CHK;
                        end
                        OP_DERIV: begin
                            n_result = deriv_w;
                            n_valid  = 1'b1;
                        end
                        OP_SQRT: begin
                            n_result = sqrt_w;
                            n_valid  = 1'b1;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    n_result = mul_product;
                    n_valid  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_result    = div_quotient;
                    n_remainder = div_remainder;
                    n_valid     = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_GCD_CHK: begin
                if (r_gb == '0) begin
                    n_result = r_ga;
                    n_valid  = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_GCD_RUN;
                end
            end
            ST_GCD_RUN: begin
                if (div_done) begin
                    n_ga    = r_gb;
                    n_gb    = div_remainder;
                    n_state = ST_GCD_CHK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign res_ext = EXT_W'(r_result);
    assign rem_ext = EXT_W'(r_remainder);
    assign o_result      = res_ext[FIELD_W-1:0];
    assign o_remainder   = rem_ext[FIELD_W-1:0];
    assign o_div_by_zero = r_dbz;

    // a result never shows while a request is still in flight
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // single-cycle operations answer in the next cycle
    a_fast_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_ADD || i_opcode == OP_DERIV ||
                            i_opcode == OP_SQRT)) |=> (o_valid && !busy))
        else $error("single-cycle operation did not answer");

    // zero divisor gives a zero quotient
    a_dbz_zero_quo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_by_zero) |-> (o_result == '0))
        else $error("nonzero quotient on division by zero");

endmodule

### hw/rtl/gf2pa_mul.sv
// ----------------------------------------------------------------------------
// gf2pa_mul
// Bit-serial carry-less multiplier. One multiplier bit per cycle, the
// multiplicand shifts left and is folded into the accumulator by XOR.
// The product is kept to WIDTH bits.
// ----------------------------------------------------------------------------
module gf2pa_mul #(
    parameter int WIDTH = gf2pa_pkg::WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_multiplicand,
    input  logic [WIDTH-1:0] i_multiplier,
    output logic             o_done,
    output logic [WIDTH-1:0] o_product
);
    import gf2pa_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [WIDTH-1:0] r_a, n_a;
    logic [WIDTH-1:0] r_b, n_b;
    logic [WIDTH-1:0] r_acc, n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        if (!r_busy) begin
            if (i_start) begin
                n_a    = i_multiplicand;
                n_b    = i_multiplier;
                n_acc  = '0;
                n_busy = 1'b1;
            end
        end else if (r_b == '0) begin
            n_done = 1'b1;
            n_busy = 1'b0;
        end else begin
            if (r_b[0]) begin
                n_acc = r_acc ^ r_a;
            end
            n_a = r_a << 1;
            n_b = r_b >> 1;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

### hw/rtl/gf2pa_div.sv
// ----------------------------------------------------------------------------
// gf2pa_div
// Bit-serial polynomial divider. The divisor is first shifted up until its
// leading coefficient sits in the top bit, then one quotient bit is formed
// per cycle while the divisor shifts back down. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module gf2pa_div #(
    parameter int WIDTH = gf2pa_pkg::WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder
);
    import gf2pa_pkg::*;

    localparam logic [WIDTH-1:0] ONE = WIDTH'(1);
    localparam logic [WIDTH-1:0] TOP = ONE << (WIDTH - 1);

    t_div_state       r_state, n_state;
    logic             r_done, n_done;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_div, n_div;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_top, n_top;
    logic [WIDTH-1:0] r_mark, n_mark;
    logic             hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_quo  <= n_quo;
        r_top  <= n_top;
        r_mark <= n_mark;
    end

    // leading coefficient of the partial remainder under the divisor
    assign hit = |(r_rem & r_top);

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_div   = r_div;
        n_quo   = r_quo;
        n_top   = r_top;
        n_mark  = r_mark;
        unique case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    n_rem   = i_dividend;
                    n_div   = i_divisor;
                    n_quo   = '0;
                    n_top   = TOP;
                    n_mark  = ONE;
                    n_state = DV_NORM;
                end
            end
            DV_NORM: begin
                if (r_div[WIDTH-1]) begin
                    n_state = DV_STEP;
                end else begin
                    n_div  = r_div << 1;
                    n_mark = r_mark << 1;
                end
            end
            DV_STEP: begin
                if (hit) begin
                    n_rem = r_rem ^ r_div;
                end
                n_quo  = {r_quo[WIDTH-2:0], hit};
                n_div  = r_div >> 1;
                n_top  = r_top >> 1;
                n_mark = r_mark >> 1;
                if (r_mark[0]) begin
                    n_done  = 1'b1;
                    n_state = DV_IDLE;
                end
            end
            default: begin
                n_state = DV_IDLE;
            end
        endcase
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for gf2_polynomial_alu. Requests are sent through
// the start/busy handshake with random idle gaps and bursts with no gaps at
// all. Every accepted request is predicted in the bench, and each strobed
// result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import gf2pa_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 10_000_000;
    localparam logic [OP_W-1:0] OP_UNUSED6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED7 = 3'd7;

    typedef struct packed {
        logic [FIELD_W-1:0] result;
        logic [FIELD_W-1:0] remainder;
        logic               div_by_zero;
    } t_alu_answer;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [OP_W-1:0]    i_opcode = '0;
    logic [FIELD_W-1:0] i_operand_a = '0;
    logic [FIELD_W-1:0] i_operand_b = '0;
    logic               o_valid;
    logic [FIELD_W-1:0] o_result;
    logic [FIELD_W-1:0] o_remainder;
    logic               o_div_by_zero;

    t_alu_answer pending_answers[$];
    int unsigned op_counts[8];
    int unsigned results_checked = 0;
    int unsigned zero_divides = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    gf2_polynomial_alu dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .o_valid       (o_valid),
        .o_result      (o_result),
        .o_remainder   (o_remainder),
        .o_div_by_zero (o_div_by_zero)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gf2_polynomial_alu regression: fail");
            $finish;
        end
    end

    // polynomial arithmetic over GF(2)
    function automatic int poly_degree(logic [FIELD_W-1:0] p);
        int d;
        d = 0;
        for (int i = 0; i < FIELD_W; i++)
            if (p[i]) d = i;
        return d;
    endfunction

    function automatic logic [FIELD_W-1:0] clmul_trunc(logic [FIELD_W-1:0] a,
                                                       logic [FIELD_W-1:0] b);
        logic [2*FIELD_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < FIELD_W; i++)
            if (b[i]) acc ^= {{FIELD_W{1'b0}}, a} << i;
        return acc[FIELD_W-1:0];
    endfunction

    function automatic void poly_divide(input logic [FIELD_W-1:0] a,
                                        input logic [FIELD_W-1:0] b,
                                        output logic [FIELD_W-1:0] quo,
                                        output logic [FIELD_W-1:0] rem);
        int db;
        db = poly_degree(b);
        quo = '0;
        rem = a;
        for (int s = poly_degree(a) - db; s >= 0; s--) begin
            if (rem[db+s]) begin
                rem ^= b << s;
                quo[s] = 1'b1;
            end
        end
    endfunction

    function automatic logic [FIELD_W-1:0] poly_gcd(logic [FIELD_W-1:0] a,
                                                    logic [FIELD_W-1:0] b);
        logic [FIELD_W-1:0] q;
        logic [FIELD_W-1:0] r;
        for (int guard = 0; guard < 130 && b != 0; guard++) begin
            poly_divide(a, b, q, r);
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic t_alu_answer compute_answer(logic [OP_W-1:0] op,
                                                   logic [FIELD_W-1:0] a,
                                                   logic [FIELD_W-1:0] b);
        t_alu_answer ans;
        ans = '0;
        case (op)
            OP_ADD: ans.result = a ^ b;
            OP_MUL: ans.result = clmul_trunc(a, b);
            OP_DIV: begin
                if (b == 0) begin
                    ans.remainder = a;
                    ans.div_by_zero = 1'b1;
                end else begin
                    poly_divide(a, b, ans.result, ans.remainder);
                end
            end
            OP_GCD: ans.result = poly_gcd(a, b);
            OP_DERIV: ans.result = (a & ODD_PATTERN[FIELD_W-1:0]) >> 1;
            OP_SQRT: begin
                for (int k = 0; 2 * k < FIELD_W; k++)
                    ans.result[k] = a[2*k];
            end
            default: ans = '0;
        endcase
        return ans;
    endfunction

    // start low through the requested gap, then hold the request until busy is low at an edge
    task automatic issue_request(logic [OP_W-1:0] op, logic [FIELD_W-1:0] a,
                                 logic [FIELD_W-1:0] b, int gap);
        t_alu_answer ans;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (busy);
        ans = compute_answer(op, a, b);
        pending_answers = {pending_answers, ans};
        op_counts[op]++;
        if (ans.div_by_zero) zero_divides++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [FIELD_W-1:0] draw_operand();
        int k;
        case ($urandom_range(0, 3))
            0, 1: return $urandom;
            2: begin
                k = $urandom_range(0, FIELD_W);
                return (k == FIELD_W) ? $urandom : $urandom & ((32'd1 << k) - 1);
            end
            default: return 32'd1 << $urandom_range(0, FIELD_W - 1);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] draw_opcode();
        case ($urandom_range(0, 15))
            0, 1: return OP_ADD;
            2, 3: return OP_MUL;
            4, 5, 6: return OP_DIV;
            7, 8, 9: return OP_GCD;
            10, 11: return OP_DERIV;
            12, 13: return OP_SQRT;
            14: return OP_UNUSED6;
            default: return OP_UNUSED7;
        endcase
    endfunction

    task automatic compare_field(string field, logic [FIELD_W-1:0] want,
                                 logic [FIELD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_alu_answer want;
        if (i_rst_n && o_valid) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: result with no request outstanding, expected none, actual %h",
                         $time, o_result);
                mismatches++;
            end else begin
                want = pending_answers.pop_front();
                compare_field("result", want.result, o_result);
                compare_field("remainder", want.remainder, o_remainder);
                compare_field("div_by_zero", 32'(want.div_by_zero), 32'(o_div_by_zero));
                results_checked++;
            end
        end
    end

    task automatic test_corner_cases();
        issue_request(OP_ADD, 32'h0, 32'h0, $urandom_range(0, 17));
        issue_request(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom_range(0, 17));
        issue_request(OP_ADD, 32'hFFFF_FFFF, 32'h0, $urandom_range(0, 17));
        issue_request(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom_range(0, 17));
        issue_request(OP_MUL, 32'h8000_0000, 32'h2, $urandom_range(0, 17));
        issue_request(OP_MUL, 32'h0000_0003, 32'h0, $urandom_range(0, 17));
        // zero divisor
        issue_request(OP_DIV, 32'hDEAD_BEEF, 32'h0, $urandom_range(0, 17));
        issue_request(OP_DIV, 32'h0, 32'h0, $urandom_range(0, 17));
        // dividend of lower degree than divisor
        issue_request(OP_DIV, 32'h0000_0003, 32'h0000_0100, $urandom_range(0, 17));
        issue_request(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0003, $urandom_range(0, 17));
        issue_request(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0001, $urandom_range(0, 17));
        issue_request(OP_DIV, 32'h8000_0000, 32'h8000_0000, $urandom_range(0, 17));
        issue_request(OP_DIV, 32'h0, 32'hFFFF_FFFF, $urandom_range(0, 17));
        // gcd with zero operands
        issue_request(OP_GCD, 32'h1234_5679, 32'h0, $urandom_range(0, 17));
        issue_request(OP_GCD, 32'h0, 32'h8765_4321, $urandom_range(0, 17));
        issue_request(OP_GCD, 32'h0, 32'h0, $urandom_range(0, 17));
        issue_request(OP_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom_range(0, 17));
        issue_request(OP_GCD, 32'h8000_0000, 32'hFFFF_FFFF, $urandom_range(0, 17));
        issue_request(OP_DERIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom_range(0, 17));
        issue_request(OP_DERIV, 32'h5555_5555, 32'h0, $urandom_range(0, 17));
        issue_request(OP_SQRT, 32'hFFFF_FFFF, 32'h0, $urandom_range(0, 17));
        // odd coefficients ignored
        issue_request(OP_SQRT, 32'hAAAA_AAAA, 32'hFFFF_FFFF, $urandom_range(0, 17));
        issue_request(OP_SQRT, 32'h5555_5555, 32'h0, $urandom_range(0, 17));
        issue_request(OP_UNUSED6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom_range(0, 17));
        issue_request(OP_UNUSED7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom_range(0, 17));
    endtask

    task automatic test_back_to_back_single_cycle();
        logic [OP_W-1:0] op;
        for (int i = 0; i < 40; i++) begin
            case ($urandom_range(0, 3))
                0: op = OP_ADD;
                1: op = OP_DERIV;
                2: op = OP_SQRT;
                default: op = ($urandom_range(0, 1) != 0) ? OP_UNUSED6 : OP_UNUSED7;
            endcase
            issue_request(op, $urandom, $urandom, 0);
        end
    endtask

    task automatic test_pause_until_drained();
        for (int i = 0; i < 30; i++) begin
            issue_request(($urandom_range(0, 1) != 0) ? OP_GCD : OP_DIV,
                          draw_operand(), draw_operand(), $urandom_range(0, 3));
            if (i % 10 == 9) wait_drained();
        end
    endtask

    task automatic test_random_mix(int count);
        logic [OP_W-1:0] op;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] common;
        bit no_gaps;
        no_gaps = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            op = draw_opcode();
            a = draw_operand();
            b = draw_operand();
            // shared factor, so that euclid ends on a multiple of it, nontrivial unless the factor is 1
            if (op == OP_GCD && $urandom_range(0, 1) != 0) begin
                common = $urandom_range(1, 2047);
                a = clmul_trunc(common, $urandom_range(1, 2047));
                b = clmul_trunc(common, $urandom_range(1, 2047));
            end
            issue_request(op, a, b, no_gaps ? 0 : $urandom_range(0, 17));
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_cases();
        test_back_to_back_single_cycle();
        test_pause_until_drained();
        test_random_mix(1360);
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("sent add %0d, mul %0d, div %0d, gcd %0d, deriv %0d, sqrt %0d, unused %0d",
                 op_counts[OP_ADD], op_counts[OP_MUL], op_counts[OP_DIV], op_counts[OP_GCD],
                 op_counts[OP_DERIV], op_counts[OP_SQRT],
                 op_counts[OP_UNUSED6] + op_counts[OP_UNUSED7]);
        $display("%0d results checked, %0d zero divisors, %0d mismatches",
                 results_checked, zero_divides, mismatches);
        if (mismatches == 0) begin
            $display("gf2_polynomial_alu regression: pass");
        end else begin
            $display("gf2_polynomial_alu regression: fail");
        end
        $finish;
    end

endmodule
